### design/rpn_pkg.sv
// Shared types and constants for the RPN stack evaluator.
`default_nettype none
package rpn_pkg;
  localparam int STACK_DEPTH = 16;
  localparam int WORD_BITS   = 64;
  localparam int HALF_BITS   = WORD_BITS / 2;
  localparam int PTR_BITS    = $clog2(STACK_DEPTH);
  localparam int CNT_BITS    = $clog2(STACK_DEPTH + 1);
  localparam int SHIFT_BITS  = $clog2(WORD_BITS + 1);

  localparam logic [2:0] OP_PUSH = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;
  localparam logic [2:0] OP_EOL  = 3'd5;

  localparam logic [2:0] ST_VALID    = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_FEW      = 3'd2;
  localparam logic [2:0] ST_DIVZERO  = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  // Commands from controller to datapath.
  typedef struct packed {
    logic push;      // write operand at count, count+1
    logic rd_top;    // read entry count-1 into right
    logic rd_next;   // read entry count-2 into left
    logic pop2;      // count-2
    logic exec;      // compute result from left/right (add/sub)
    logic mul_start; // clear product accumulator
    logic mul_step;  // add one partial product
    logic div_start; // load divider
    logic div_step;  // one quotient bit
    logic wr_res;    // write result at count, count+1
    logic wr_div;    // write quotient at count, count+1
  } rpn_cmd_t;

  typedef struct packed {
    logic [CNT_BITS-1:0] count;
    logic                right_zero;
    logic                mul_done;
    logic                div_done;
  } rpn_stat_t;
endpackage
`default_nettype wire

### design/rpn_datapath.sv
// Stack memory, operand registers, ALU and bit-serial divider.
`default_nettype none
module rpn_datapath
  import rpn_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire rpn_cmd_t             cmd,
  input  wire logic [2:0]           op,
  input  wire logic [63:0]          operand_value,
  output rpn_stat_t                 stat,
  output logic [WORD_BITS-1:0]      right
);
  logic [WORD_BITS-1:0] mem [STACK_DEPTH];
  logic [CNT_BITS-1:0]  count;
  logic [WORD_BITS-1:0] left, res;
  logic [WORD_BITS-1:0] rem, quo, dvs;
  logic                 qneg;
  logic [SHIFT_BITS-1:0] steps;
  logic [WORD_BITS-1:0] sum;
  logic [WORD_BITS:0]   trial;
  logic [WORD_BITS-1:0] mag_l, mag_r, shifted_rem;
  logic [1:0]           mphase;
  logic [HALF_BITS-1:0] mul_a, mul_b;
  logic [WORD_BITS-1:0] prod;

  assign mag_l = left[WORD_BITS-1]  ? -left  : left;
  assign mag_r = right[WORD_BITS-1] ? -right : right;

  always_comb begin
    unique case (op)
      OP_SUB:  sum = left - right;
      default: sum = left + right;
    endcase
  end

  // Build the low word of the product from three half-width partial products,
  // one per cycle; the high-by-high term falls outside the word.
  always_comb begin
    unique case (mphase)
      2'd0: begin
        mul_a = left[HALF_BITS-1:0];
        mul_b = right[HALF_BITS-1:0];
      end
      2'd1: begin
        mul_a = left[HALF_BITS-1:0];
        mul_b = right[WORD_BITS-1:HALF_BITS];
      end
      default: begin
        mul_a = left[WORD_BITS-1:HALF_BITS];
        mul_b = right[HALF_BITS-1:0];
      end
    endcase
  end

  assign prod = {{HALF_BITS{1'b0}}, mul_a} * {{HALF_BITS{1'b0}}, mul_b};

  // Restoring division: shift next dividend bit into remainder.
  assign shifted_rem = {rem[WORD_BITS-2:0], quo[WORD_BITS-1]};
  assign trial = {1'b0, shifted_rem} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      steps  <= '0;
      mphase <= '0;
    end else begin
      if (cmd.push || cmd.wr_res || cmd.wr_div) count <= count + 1'b1;
      else if (cmd.pop2) count <= count - CNT_BITS'(2);
      if (cmd.div_start) steps <= SHIFT_BITS'(WORD_BITS);
      else if (cmd.div_step) steps <= steps - 1'b1;
      if (cmd.mul_start) mphase <= '0;
      else if (cmd.mul_step) mphase <= mphase + 1'b1;
    end
    if (cmd.push) mem[count[PTR_BITS-1:0]] <= operand_value[WORD_BITS-1:0];
    if (cmd.wr_res) mem[count[PTR_BITS-1:0]] <= res;
    if (cmd.wr_div) mem[count[PTR_BITS-1:0]] <= qneg ? -quo : quo;
    if (cmd.rd_top) right <= mem[PTR_BITS'(count - 1'b1)];
    if (cmd.rd_next) left <= mem[PTR_BITS'(count - CNT_BITS'(2))];
    if (cmd.exec) res <= sum;
    else if (cmd.mul_start) res <= '0;
    else if (cmd.mul_step)
      res <= res + ((mphase == 2'd0) ? prod
                                      : {prod[HALF_BITS-1:0], {HALF_BITS{1'b0}}});
    if (cmd.div_start) begin
      rem  <= '0;
      quo  <= mag_l;
      dvs  <= mag_r;
      qneg <= left[WORD_BITS-1] ^ right[WORD_BITS-1];
    end else if (cmd.div_step) begin
      if (!trial[WORD_BITS]) begin
        rem <= trial[WORD_BITS-1:0];
        quo <= {quo[WORD_BITS-2:0], 1'b1};
      end else begin
        rem <= shifted_rem;
        quo <= {quo[WORD_BITS-2:0], 1'b0};
      end
    end
  end

  assign stat.count      = count;
  assign stat.right_zero = (right == '0);
  assign stat.mul_done   = (mphase == 2'd3);
  assign stat.div_done   = (steps == '0);
endmodule
`default_nettype wire

### design/rpn_ctrl.sv
// Sequencing state machine for the RPN stack evaluator.
`default_nettype none
module rpn_ctrl
  import rpn_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [2:0]       opcode,
  input  wire rpn_stat_t        stat,
  input  wire logic [WORD_BITS-1:0] right,
  output logic                  busy,
  output rpn_cmd_t              cmd,
  output logic [2:0]            op,
  output logic                  done,
  output logic [2:0]            status,
  output logic [63:0]           top_value
);
  typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_MUL, S_DIV, S_EOL} state_t;
  state_t     state;
  logic [2:0] line_error;
  logic       acc;

  assign acc  = start && !busy;
  assign busy = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    if (acc && line_error == ST_VALID && opcode == OP_PUSH
        && stat.count < CNT_BITS'(STACK_DEPTH))
      cmd.push = 1'b1;
    if (acc && opcode == OP_EOL) cmd.rd_top = 1'b1;
    if (acc && line_error == ST_VALID && stat.count >= CNT_BITS'(2)
        && (opcode == OP_ADD || opcode == OP_SUB || opcode == OP_MUL
            || opcode == OP_DIV)) begin
      cmd.rd_top  = 1'b1;
      cmd.rd_next = 1'b1;
    end
    unique case (state)
      S_READ: begin
        cmd.pop2 = 1'b1;
        if (op == OP_DIV) cmd.div_start = !stat.right_zero;
        else if (op == OP_MUL) cmd.mul_start = 1'b1;
        else cmd.exec = 1'b1;
      end
      S_EXEC:  cmd.wr_res = 1'b1;
      S_MUL: begin
        if (stat.mul_done) cmd.wr_res = 1'b1;
        else cmd.mul_step = 1'b1;
      end
      S_DIV: begin
        if (stat.div_done) cmd.wr_div = 1'b1;
        else cmd.div_step = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      line_error <= ST_VALID;
      done       <= 1'b0;
      op         <= OP_PUSH;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: if (acc) begin
          op <= opcode;
          if (opcode == OP_EOL) state <= S_EOL;
          else if (line_error == ST_VALID) begin
            if (opcode == OP_PUSH) begin
              if (stat.count >= CNT_BITS'(STACK_DEPTH)) line_error <= ST_OVERFLOW;
            end else if (opcode <= OP_DIV) begin
              if (stat.count < CNT_BITS'(2)) line_error <= ST_FEW;
              else state <= S_READ;
            end
          end
        end
        S_READ: begin
          if (op == OP_MUL) state <= S_MUL;
          else if (op != OP_DIV) state <= S_EXEC;
          else if (stat.right_zero) begin
            line_error <= ST_DIVZERO;
            state      <= S_IDLE;
          end else state <= S_DIV;
        end
        S_EXEC: state <= S_IDLE;
        S_MUL:  if (stat.mul_done) state <= S_IDLE;
        S_DIV:  if (stat.div_done) state <= S_IDLE;
        S_EOL: begin
          done <= 1'b1;
          if (line_error != ST_VALID) begin
            status    <= line_error;
            top_value <= '0;
          end else if (stat.count == '0) begin
            status    <= ST_EMPTY;
            top_value <= '0;
          end else begin
            status    <= ST_VALID;
            top_value <= 64'(signed'(right));
          end
          line_error <= ST_VALID;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### design/rpn_stack_evaluator.sv
// Top level of the RPN stack evaluator.
// Raise start with opcode/operand_value; a transaction is taken at the edge
// where busy is low. Push, ignored and overflow or too-few tokens leave busy
// low; add and subtract pass through read and execute states; multiply builds
// the product from three half-width partial products one per cycle; divide
// uses the one-bit-per-cycle restoring divider; end of line raises done for
// one cycle with status and top_value in the same cycle that busy drops.
// The receiver cannot stall: take the result when done is high.
`default_nettype none
module rpn_stack_evaluator
  import rpn_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [2:0]  opcode,
  input  wire logic [63:0] operand_value,
  output logic             busy,
  output logic             done,
  output logic [2:0]       status,
  output logic [63:0]      top_value
);
  rpn_cmd_t             cmd;
  rpn_stat_t            stat;
  logic [2:0]           op;
  logic [WORD_BITS-1:0] right;

  rpn_ctrl u_ctrl (
    .clk, .rst, .start, .opcode, .stat, .right, .busy, .cmd, .op,
    .done, .status, .top_value
  );

  rpn_datapath u_dp (
    .clk, .rst, .cmd, .op, .operand_value, .stat, .right
  );

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    stat.count <= CNT_BITS'(STACK_DEPTH))
    else $error("stack count beyond depth");
  a_done_after_eol: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode == OP_EOL) |=> ##1 done)
    else $error("end of line gave no result");
  a_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_VALID) |-> top_value == '0)
    else $error("nonzero value with error status");
endmodule
`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the RPN stack evaluator: directed and random token streams.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import rpn_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [2:0]  opcode = OP_PUSH;
  logic [63:0] operand_value = '0;
  wire         busy;
  wire         done;
  wire  [2:0]  status;
  wire  [63:0] top_value;

  rpn_stack_evaluator dut (
    .clk(clk), .rst(rst), .start(start), .opcode(opcode),
    .operand_value(operand_value), .busy(busy), .done(done),
    .status(status), .top_value(top_value)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  localparam logic [2:0] OP_BAD6 = 3'd6;
  localparam logic [2:0] OP_BAD7 = 3'd7;
  localparam logic [63:0] MIN_WORD = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_WORD = 64'h7fff_ffff_ffff_ffff;
  localparam int IDLE_LIMIT = 2000;

  // Predictor state
  logic [63:0] calc_stack [STACK_DEPTH];
  int          calc_count;
  logic [2:0]  calc_err;
  logic [2:0]  exp_status_q [$];
  logic [63:0] exp_value_q [$];

  int errors, mismatches, lines_seen, items_sent, eol_sent, stall_cycles;
  bit timed_out;

  function automatic logic [63:0] trunc_div(logic [63:0] num, logic [63:0] den);
    logic [63:0] mn, md, q;
    mn = num[63] ? -num : num;
    md = den[63] ? -den : den;
    q = mn / md;
    return (num[63] != den[63]) ? -q : q;
  endfunction

  task automatic predict_token(logic [2:0] op, logic [63:0] val);
    logic [63:0] rhs, lhs, res;
    if (op == OP_EOL) begin
      if (calc_err != ST_VALID) begin
        exp_status_q.push_back(calc_err); exp_value_q.push_back('0);
      end else if (calc_count == 0) begin
        exp_status_q.push_back(ST_EMPTY); exp_value_q.push_back('0);
      end else begin
        exp_status_q.push_back(ST_VALID);
        exp_value_q.push_back(calc_stack[calc_count-1]);
      end
      calc_err = ST_VALID;
      eol_sent++;
      return;
    end
    if (op > OP_EOL || calc_err != ST_VALID) return;
    if (op == OP_PUSH) begin
      if (calc_count >= STACK_DEPTH) calc_err = ST_OVERFLOW;
      else begin
        calc_stack[calc_count] = val;
        calc_count++;
      end
      return;
    end
    if (calc_count < 2) begin
      calc_err = ST_FEW;
      return;
    end
    rhs = calc_stack[calc_count-1];
    lhs = calc_stack[calc_count-2];
    calc_count -= 2;
    case (op)
      OP_ADD: res = lhs + rhs;
      OP_SUB: res = lhs - rhs;
      OP_MUL: res = lhs * rhs;
      default: begin
        if (rhs == 0) begin
          calc_err = ST_DIVZERO;
          return;
        end
        res = trunc_div(lhs, rhs);
      end
    endcase
    calc_stack[calc_count] = res;
    calc_count++;
  endtask

  // Send one transaction after a random gap; hold until accepted.
  // Start stays high into the next call when it draws no gap.
  task automatic send_token(logic [2:0] op, logic [63:0] val);
    int gap;
    gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9));
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    operand_value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_token(op, val);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 5))
      0: return MIN_WORD;
      1: return MAX_WORD;
      2: return 64'($signed($urandom_range(0, 20)) - 10);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Result checker
  always @(posedge clk) begin
    if (!rst && done) begin
      if (exp_status_q.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result status=%0d value=%h", status, top_value);
      end else begin
        logic [2:0] es;
        logic [63:0] ev;
        es = exp_status_q.pop_front();
        ev = exp_value_q.pop_front();
        lines_seen++;
        if (status !== es || top_value !== ev) begin
          errors++;
          if (mismatches++ < 10)
            $display("mismatch line %0d: status exp %0d got %0d, value exp %h got %h",
                     lines_seen, es, status, ev, top_value);
        end
      end
    end
  end

  // Watchdog: count cycles with no accepted transaction and no result
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", stall_cycles);
      $display("[rpn_stack_evaluator] ERROR");
      $finish;
    end
  end

  task automatic test_empty_and_basic();
    send_token(OP_EOL, '0);
    send_token(OP_BAD6, 64'hffff);
    send_token(OP_BAD7, '0);
    send_token(OP_EOL, '0);
    send_token(OP_PUSH, MAX_WORD);
    send_token(OP_PUSH, 64'd1);
    send_token(OP_ADD, '0);
    send_token(OP_EOL, '0);
    send_token(OP_PUSH, MIN_WORD);
    send_token(OP_SUB, '0);
    send_token(OP_PUSH, 64'd3);
    send_token(OP_MUL, '0);
    send_token(OP_EOL, '0);
  endtask

  task automatic test_divide_cases();
    send_token(OP_PUSH, MIN_WORD);
    send_token(OP_PUSH, '1);
    send_token(OP_DIV, '0);
    send_token(OP_EOL, '0);
    send_token(OP_PUSH, -64'sd7);
    send_token(OP_PUSH, 64'd2);
    send_token(OP_DIV, '0);
    send_token(OP_PUSH, '0);
    send_token(OP_DIV, '0);
    send_token(OP_PUSH, 64'd5);
    send_token(OP_EOL, '0);
  endtask

  task automatic test_few_and_overflow();
    send_token(OP_ADD, '0);
    send_token(OP_ADD, '0);
    send_token(OP_EOL, '0);
    while (calc_count < STACK_DEPTH) send_token(OP_PUSH, rand_word());
    send_token(OP_PUSH, MAX_WORD);
    send_token(OP_EOL, '0);
  endtask

  // Mostly well-formed lines that keep the stack shallow, with some noise.
  task automatic test_random_lines(int n_items);
    int sent_here;
    logic [2:0] op;
    sent_here = 0;
    while (sent_here < n_items) begin
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 12) op = OP_EOL;
      else if (roll < 14) op = 3'($urandom_range(6, 7));
      else if (roll < 20) op = 3'($urandom_range(1, 4));
      else if (calc_count < 2) op = OP_PUSH;
      else if (calc_count > 12 && roll < 95) op = 3'($urandom_range(1, 4));
      else if (roll < 55) op = OP_PUSH;
      else op = 3'($urandom_range(1, 4));
      send_token(op, rand_word());
      sent_here++;
    end
    send_token(OP_EOL, '0);
  endtask

  initial begin
    int wait_cycles;
    errors = 0; mismatches = 0; lines_seen = 0; items_sent = 0; eol_sent = 0;
    calc_count = 0; calc_err = ST_VALID;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_and_basic();
    test_divide_cases();
    test_few_and_overflow();
    test_random_lines(1120);
    start <= 1'b0;
    wait_cycles = 0;
    while (exp_status_q.size() != 0 && wait_cycles < 1000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (80) @(posedge clk);
    if (exp_status_q.size() != 0) errors += exp_status_q.size();
    $display("Sent %0d tokens over %0d lines; %0d results checked, %0d mismatches.",
             items_sent, eol_sent, lines_seen, mismatches);
    if (errors == 0) $display("[rpn_stack_evaluator] OK");
    else $display("[rpn_stack_evaluator] ERROR");
    $finish;
  end
endmodule
`default_nettype wire

### sim.f
design/rpn_pkg.sv
design/rpn_datapath.sv
design/rpn_ctrl.sv
design/rpn_stack_evaluator.sv
tb/tb.sv
